@@ rtl/core/lrs_pkg.sv @@
// lrs_pkg: shared types, codes and constants of the landing retry supervisor.
// Used by every module under rtl/core; depends on nothing.
package lrs_pkg;

  localparam int unsigned IN_TDATA_W  = 248;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [15:0] POS_TOL_CM       = 16'd35;
  localparam logic [31:0] FAILSAFE_HOLD_MS = 32'd7000;
  localparam logic [24:0] RETRY_RISE_CM    = 25'd70;
  localparam logic [15:0] MS_PER_S         = 16'd1000;

  localparam logic [2:0] ACT_RESTART     = 3'd0;
  localparam logic [2:0] ACT_FOUND       = 3'd1;
  localparam logic [2:0] ACT_OUT_OF_RNG  = 3'd2;
  localparam logic [2:0] ACT_RECENT_LOST = 3'd3;
  localparam logic [2:0] ACT_NEVER_SEEN  = 3'd4;

  localparam logic [1:0] CMD_DESCEND = 2'd0;
  localparam logic [1:0] CMD_HOVER   = 2'd1;
  localparam logic [1:0] CMD_GOTO    = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] MSG_NONE      = 2'd0;
  localparam logic [1:0] MSG_RETRYING  = 2'd1;
  localparam logic [1:0] MSG_RETRY_END = 2'd2;
  localparam logic [1:0] MSG_FAILSAFE  = 2'd3;

  localparam logic [1:0] STRICT_NONE   = 2'd0;
  localparam logic [1:0] STRICT_NORMAL = 2'd1;

  localparam logic [1:0] SRC_VEHICLE = 2'd1;
  localparam logic [1:0] SRC_TARGET  = 2'd2;

  localparam logic [1:0] REG_STRICTNESS  = 2'd0;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] REG_MIN_WAIT_S  = 2'd2;
  localparam logic [1:0] REG_RETRY_SRC   = 2'd3;

  typedef struct packed {
    logic [1:0] strictness;
    logic [3:0] max_retries;
    logic [5:0] min_retry_wait_s;
    logic [1:0] retry_source;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        now_ms;
    logic [31:0]        target_age_ms;
    logic               pilot_repositioning;
    logic [15:0]        err_xy_cm;
    logic signed [15:0] err_z_cm;
    logic signed [23:0] target_x_cm;
    logic signed [23:0] target_y_cm;
    logic signed [23:0] target_z_cm;
    logic signed [23:0] vehicle_x_cm;
    logic signed [23:0] vehicle_y_cm;
    logic signed [23:0] vehicle_z_cm;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] goto_x_cm;
    logic signed [23:0] goto_y_cm;
    logic signed [24:0] goto_z_cm;
    logic               init_retry_ctrl;
    logic               init_failsafe_ctrl;
    logic [1:0]         message;
  } out_item_t;

endpackage

@@ rtl/core/landing_retry_supervisor.sv @@
// landing_retry_supervisor: top level; input register, decision core,
// output register and configuration port. Depends on lrs_pkg, lrs_cfg_regs, lrs_core.
// An accepted input word goes to the input register, then to the output register.
// Throughput: one word per cycle unless out_tready holds the output register; the
// decision core works between the input and output registers and updates its state
// as a word moves into the output register.
// Reset (rst_n low, synchronous): both stages empty, state cleared, registers at defaults.
module landing_retry_supervisor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_ms, target_age_ms, pilot_repositioning, err_xy_cm, err_z_cm,
  // target_x/y/z_cm, vehicle_x/y/z_cm, zero pad
  input  logic [lrs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [lrs_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // goto_x_cm, goto_y_cm, goto_z_cm, init_retry_ctrl, init_failsafe_ctrl,
  // message, zero pad
  output logic [lrs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // command
  output logic [lrs_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lrs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  lrs_pkg::cfg_t      cfg;
  lrs_pkg::in_item_t  in_item, s1_item_r;
  lrs_pkg::out_item_t res, out_item_r;
  logic               s1_valid_r;
  logic               out_valid_r;
  logic               advance;
  logic               fire;

  assign in_item.action              = in_tuser;
  assign in_item.now_ms              = in_tdata[31:0];
  assign in_item.target_age_ms       = in_tdata[63:32];
  assign in_item.pilot_repositioning = in_tdata[64];
  assign in_item.err_xy_cm           = in_tdata[80:65];
  assign in_item.err_z_cm            = in_tdata[96:81];
  assign in_item.target_x_cm         = in_tdata[120:97];
  assign in_item.target_y_cm         = in_tdata[144:121];
  assign in_item.target_z_cm         = in_tdata[168:145];
  assign in_item.vehicle_x_cm        = in_tdata[192:169];
  assign in_item.vehicle_y_cm        = in_tdata[216:193];
  assign in_item.vehicle_z_cm        = in_tdata[240:217];

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  lrs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance)   out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_item_r  <= in_item;
    if (fire)                   out_item_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.command;
  assign out_tdata  = {3'd0, out_item_r.message, out_item_r.init_failsafe_ctrl,
                       out_item_r.init_retry_ctrl, out_item_r.goto_z_cm,
                       out_item_r.goto_y_cm, out_item_r.goto_x_cm};

  a_goto_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.command != lrs_pkg::CMD_GOTO |->
      out_item_r.goto_x_cm == '0 && out_item_r.goto_y_cm == '0 && out_item_r.goto_z_cm == '0)
    else $error("retry point set without goto command");

  a_retry_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.init_retry_ctrl |->
      out_item_r.command == lrs_pkg::CMD_GOTO && out_item_r.message == lrs_pkg::MSG_RETRYING)
    else $error("retry init without goto and retry message");

  a_fs_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.init_failsafe_ctrl |->
      out_item_r.message == lrs_pkg::MSG_FAILSAFE && !out_item_r.init_retry_ctrl)
    else $error("failsafe init without failsafe message");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_item_r) && !$past(fire))
    else $error("result register changed while stalled");

endmodule

@@ rtl/core/lrs_cfg_regs.sv @@
// lrs_cfg_regs: APB-style configuration registers of the supervisor.
// Depends on lrs_pkg.
module lrs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lrs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lrs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output lrs_pkg::cfg_t                  cfg
);

  lrs_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strictness       <= 2'd1;
      cfg_r.max_retries      <= 4'd1;
      cfg_r.min_retry_wait_s <= 6'd2;
      cfg_r.retry_source     <= 2'd1;
    end else if (wr_en) begin
      case (reg_idx)
        lrs_pkg::REG_STRICTNESS:  cfg_r.strictness       <= pwdata[1:0];
        lrs_pkg::REG_MAX_RETRIES: cfg_r.max_retries      <= pwdata[3:0];
        lrs_pkg::REG_MIN_WAIT_S:  cfg_r.min_retry_wait_s <= pwdata[5:0];
        lrs_pkg::REG_RETRY_SRC:   cfg_r.retry_source     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      lrs_pkg::REG_STRICTNESS:  prdata = 32'(cfg_r.strictness);
      lrs_pkg::REG_MAX_RETRIES: prdata = 32'(cfg_r.max_retries);
      lrs_pkg::REG_MIN_WAIT_S:  prdata = 32'(cfg_r.min_retry_wait_s);
      lrs_pkg::REG_RETRY_SRC:   prdata = 32'(cfg_r.retry_source);
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/lrs_core.sv @@
// lrs_core: landing state (lost phase, retry phase, failsafe, retry count)
// and the single-pass command decision. Depends on lrs_pkg.
module lrs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  lrs_pkg::in_item_t  item,
  input  lrs_pkg::cfg_t      cfg,
  output lrs_pkg::out_item_t res
);

  typedef enum logic [1:0] {
    LP_DECIDE   = 2'd0,
    LP_DESCEND  = 2'd1,
    LP_RETRY    = 2'd2,
    LP_VERTICAL = 2'd3
  } lost_phase_t;

  typedef enum logic [1:0] {
    RP_INIT = 2'd0,
    RP_BUSY = 2'd1,
    RP_DONE = 2'd2
  } retry_phase_t;

  lost_phase_t  lost_phase_r,  lost_phase_nxt;
  retry_phase_t retry_phase_r, retry_phase_nxt;
  logic         fs_started_r,  fs_started_nxt;
  logic [31:0]  fs_time_r,     fs_time_nxt;
  logic [4:0]   retries_r,     retries_nxt;

  logic               do_fs;
  logic [31:0]        fs_elapsed;
  logic [15:0]        wait_ms;
  logic               retry_blocked;
  logic               in_tol;
  logic signed [23:0] src_x, src_y, src_z;

  assign fs_elapsed = item.now_ms - fs_time_r;
  assign wait_ms    = 16'(cfg.min_retry_wait_s) * lrs_pkg::MS_PER_S;
  assign retry_blocked = (retries_r > {1'b0, cfg.max_retries}) || (cfg.max_retries == 4'd0)
                      || item.pilot_repositioning || (retry_phase_r == RP_DONE);
  assign in_tol = (item.err_xy_cm < lrs_pkg::POS_TOL_CM)
               && (item.err_z_cm < $signed(lrs_pkg::POS_TOL_CM))
               && (item.err_z_cm > -$signed(lrs_pkg::POS_TOL_CM));

  always_comb begin
    case (cfg.retry_source)
      lrs_pkg::SRC_TARGET: begin
        src_x = item.target_x_cm;
        src_y = item.target_y_cm;
        src_z = item.target_z_cm;
      end
      lrs_pkg::SRC_VEHICLE: begin
        src_x = item.vehicle_x_cm;
        src_y = item.vehicle_y_cm;
        src_z = item.vehicle_z_cm;
      end
      default: begin
        src_x = '0;
        src_y = '0;
        src_z = '0;
      end
    endcase
  end

  always_comb begin
    lost_phase_nxt  = lost_phase_r;
    retry_phase_nxt = retry_phase_r;
    fs_started_nxt  = fs_started_r;
    fs_time_nxt     = fs_time_r;
    retries_nxt     = retries_r;
    do_fs           = 1'b0;
    res             = '0;
    res.command     = lrs_pkg::CMD_NONE;

    case (item.action)
      lrs_pkg::ACT_RESTART: begin
        retries_nxt     = '0;
        lost_phase_nxt  = LP_DECIDE;
        retry_phase_nxt = RP_INIT;
        fs_started_nxt  = 1'b0;
      end
      lrs_pkg::ACT_FOUND, lrs_pkg::ACT_OUT_OF_RNG: begin
        res.command     = lrs_pkg::CMD_DESCEND;
        lost_phase_nxt  = LP_DECIDE;
        retry_phase_nxt = RP_INIT;
        fs_started_nxt  = 1'b0;
      end
      lrs_pkg::ACT_RECENT_LOST: begin
        case (lost_phase_r)
          LP_DECIDE: begin
            lost_phase_nxt = (cfg.strictness == lrs_pkg::STRICT_NONE) ? LP_VERTICAL
                                                                       : LP_DESCEND;
          end
          LP_DESCEND: begin
            res.command = lrs_pkg::CMD_DESCEND;
            if (item.target_age_ms >= {16'd0, wait_ms}) begin
              lost_phase_nxt  = LP_RETRY;
              retry_phase_nxt = RP_INIT;
            end
          end
          LP_RETRY: begin
            if (retry_blocked) begin
              do_fs = 1'b1;
            end else begin
              res.command   = lrs_pkg::CMD_GOTO;
              res.goto_x_cm = src_x;
              res.goto_y_cm = src_y;
              res.goto_z_cm = 25'(src_z) - lrs_pkg::RETRY_RISE_CM;
              if (retry_phase_r == RP_INIT) begin
                if (retries_r != 5'd31) retries_nxt = retries_r + 5'd1;
                res.init_retry_ctrl = 1'b1;
                res.message         = lrs_pkg::MSG_RETRYING;
                retry_phase_nxt     = RP_BUSY;
              end else if (in_tol) begin
                retry_phase_nxt = RP_DONE;
                res.message     = lrs_pkg::MSG_RETRY_END;
              end
            end
          end
          default: res.command = lrs_pkg::CMD_DESCEND;
        endcase
      end
      lrs_pkg::ACT_NEVER_SEEN: do_fs = 1'b1;
      default: ;
    endcase

    if (do_fs) begin
      if (!fs_started_r) begin
        fs_time_nxt            = item.now_ms;
        fs_started_nxt         = 1'b1;
        res.init_failsafe_ctrl = 1'b1;
        res.message            = lrs_pkg::MSG_FAILSAFE;
      end
      case (cfg.strictness)
        lrs_pkg::STRICT_NONE:   res.command = lrs_pkg::CMD_DESCEND;
        lrs_pkg::STRICT_NORMAL: begin
          res.command = (!fs_started_r || fs_elapsed < lrs_pkg::FAILSAFE_HOLD_MS)
                        ? lrs_pkg::CMD_HOVER : lrs_pkg::CMD_DESCEND;
        end
        default:                res.command = lrs_pkg::CMD_HOVER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_phase_r  <= LP_DECIDE;
      retry_phase_r <= RP_INIT;
      fs_started_r  <= 1'b0;
      fs_time_r     <= '0;
      retries_r     <= '0;
    end else if (fire) begin
      lost_phase_r  <= lost_phase_nxt;
      retry_phase_r <= retry_phase_nxt;
      fs_started_r  <= fs_started_nxt;
      fs_time_r     <= fs_time_nxt;
      retries_r     <= retries_nxt;
    end
  end

endmodule

@@ tb/sv/landing_decision_checker.sv @@
// landing_decision_checker: watches the config port and both streams of
// landing_retry_supervisor, predicts each result word and compares it.
// Depends on lrs_pkg.
module landing_decision_checker
  import lrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  input  logic                   pready,
  output int                     pending,
  output int                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] LOST_DECIDE   = 2'd0;
  localparam logic [1:0] LOST_DESCEND  = 2'd1;
  localparam logic [1:0] LOST_RETRY    = 2'd2;
  localparam logic [1:0] RETRY_INIT    = 2'd0;
  localparam logic [1:0] RETRY_BUSY    = 2'd1;
  localparam logic [1:0] RETRY_DONE    = 2'd2;
  localparam logic [1:0] LOST_VERTICAL = 2'd3;
  localparam logic [4:0] RETRY_CNT_MAX = 5'd31;

  logic [1:0]  strict_r;
  logic [3:0]  max_retry_r;
  logic [5:0]  wait_s_r;
  logic [1:0]  src_r;

  logic [1:0]  lost_ph;
  logic [1:0]  retry_ph;
  logic        fs_on;
  logic [31:0] fs_t0;
  logic [4:0]  retry_cnt;

  out_item_t   cmd_due_q[$];

  initial mismatches = 0;
  initial pending = 0;

  function automatic void run_failsafe(input logic [31:0] now, inout out_item_t o);
    if (!fs_on) begin
      fs_t0 = now;
      fs_on = 1'b1;
      o.init_failsafe_ctrl = 1'b1;
      o.message = MSG_FAILSAFE;
    end
    if (strict_r == STRICT_NONE) begin
      o.command = CMD_DESCEND;
    end else if (strict_r == STRICT_NORMAL) begin
      o.command = ((now - fs_t0) < FAILSAFE_HOLD_MS) ? CMD_HOVER : CMD_DESCEND;
    end else begin
      o.command = CMD_HOVER;
    end
  endfunction

  function automatic void plan_retry(input in_item_t w, inout out_item_t o);
    logic signed [24:0] px, py, pz;
    int exy, ez;
    if (retry_cnt > 5'(max_retry_r) || max_retry_r == 4'd0 || w.pilot_repositioning ||
        retry_ph >= RETRY_DONE) begin
      run_failsafe(w.now_ms, o);
      return;
    end
    case (src_r)
      SRC_TARGET: begin
        px = w.target_x_cm;
        py = w.target_y_cm;
        pz = w.target_z_cm;
      end
      SRC_VEHICLE: begin
        px = w.vehicle_x_cm;
        py = w.vehicle_y_cm;
        pz = w.vehicle_z_cm;
      end
      default: begin
        px = '0;
        py = '0;
        pz = '0;
      end
    endcase
    o.command = CMD_GOTO;
    o.goto_x_cm = px[23:0];
    o.goto_y_cm = py[23:0];
    o.goto_z_cm = pz - $signed(RETRY_RISE_CM);
    if (retry_ph == RETRY_INIT) begin
      if (retry_cnt < RETRY_CNT_MAX) retry_cnt = retry_cnt + 5'd1;
      o.init_retry_ctrl = 1'b1;
      o.message = MSG_RETRYING;
      retry_ph = RETRY_BUSY;
    end else begin
      exy = w.err_xy_cm;
      ez = w.err_z_cm;
      if (ez < 0) ez = -ez;
      if (exy < int'(POS_TOL_CM) && ez < int'(POS_TOL_CM)) begin
        retry_ph = RETRY_DONE;
        o.message = MSG_RETRY_END;
      end
    end
  endfunction

  function automatic out_item_t next_landing_cmd(input in_item_t w);
    out_item_t o;
    o = '0;
    o.command = CMD_NONE;
    case (w.action)
      ACT_RESTART: begin
        retry_cnt = '0;
        lost_ph = LOST_DECIDE;
        retry_ph = RETRY_INIT;
        fs_on = 1'b0;
      end
      ACT_FOUND, ACT_OUT_OF_RNG: begin
        o.command = CMD_DESCEND;
        lost_ph = LOST_DECIDE;
        retry_ph = RETRY_INIT;
        fs_on = 1'b0;
      end
      ACT_RECENT_LOST: begin
        case (lost_ph)
          LOST_DECIDE: lost_ph = (strict_r == STRICT_NONE) ? LOST_VERTICAL : LOST_DESCEND;
          LOST_DESCEND: begin
            o.command = CMD_DESCEND;
            if (w.target_age_ms >= 32'(wait_s_r) * 32'(MS_PER_S)) begin
              lost_ph = LOST_RETRY;
              retry_ph = RETRY_INIT;
            end
          end
          LOST_RETRY: plan_retry(w, o);
          default: o.command = CMD_DESCEND;
        endcase
      end
      ACT_NEVER_SEEN: run_failsafe(w.now_ms, o);
      default: ;
    endcase
    return o;
  endfunction

  function automatic in_item_t unpack_in(input logic [IN_TUSER_W-1:0] u,
                                         input logic [IN_TDATA_W-1:0] d);
    in_item_t w;
    w.action              = u;
    w.now_ms              = d[31:0];
    w.target_age_ms       = d[63:32];
    w.pilot_repositioning = d[64];
    w.err_xy_cm           = d[80:65];
    w.err_z_cm            = d[96:81];
    w.target_x_cm         = d[120:97];
    w.target_y_cm         = d[144:121];
    w.target_z_cm         = d[168:145];
    w.vehicle_x_cm        = d[192:169];
    w.vehicle_y_cm        = d[216:193];
    w.vehicle_z_cm        = d[240:217];
    return w;
  endfunction

  function automatic out_item_t unpack_out(input logic [OUT_TUSER_W-1:0] u,
                                           input logic [OUT_TDATA_W-1:0] d);
    out_item_t r;
    r.command            = u;
    r.goto_x_cm          = d[23:0];
    r.goto_y_cm          = d[47:24];
    r.goto_z_cm          = d[72:48];
    r.init_retry_ctrl    = d[73];
    r.init_failsafe_ctrl = d[74];
    r.message            = d[76:75];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst_n) begin
      strict_r    <= 2'd1;
      max_retry_r <= 4'd1;
      wait_s_r    <= 6'd2;
      src_r       <= 2'd1;
      lost_ph     = LOST_DECIDE;
      retry_ph    = RETRY_INIT;
      fs_on       = 1'b0;
      fs_t0       = '0;
      retry_cnt   = '0;
      cmd_due_q.delete();
      pending     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_STRICTNESS:  strict_r    <= pwdata[1:0];
          REG_MAX_RETRIES: max_retry_r <= pwdata[3:0];
          REG_MIN_WAIT_S:  wait_s_r    <= pwdata[5:0];
          REG_RETRY_SRC:   src_r       <= pwdata[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        cmd_due_q.push_back(next_landing_cmd(unpack_in(in_tuser, in_tdata)));
      if (out_tvalid && out_tready) begin
        got = unpack_out(out_tuser, out_tdata);
        if (cmd_due_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none got %h", $time, got);
          mismatches++;
        end else begin
          want = cmd_due_q.pop_front();
          check_field("command", want.command, got.command);
          check_field("goto_x_cm", want.goto_x_cm, got.goto_x_cm);
          check_field("goto_y_cm", want.goto_y_cm, got.goto_y_cm);
          check_field("goto_z_cm", want.goto_z_cm, got.goto_z_cm);
          check_field("init_retry_ctrl", want.init_retry_ctrl, got.init_retry_ctrl);
          check_field("init_failsafe_ctrl", want.init_failsafe_ctrl, got.init_failsafe_ctrl);
          check_field("message", want.message, got.message);
        end
      end
      pending <= cmd_due_q.size();
    end
  end

endmodule

@@ tb/sv/landing_retry_supervisor_tb.sv @@
// landing_retry_supervisor_tb: clock, reset, config writes and landing-tick
// stimulus with random idling on both streams. Depends on lrs_pkg,
// landing_retry_supervisor and landing_decision_checker.
module landing_retry_supervisor_tb;
  import lrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 165;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int pending;
  int mismatches;
  int cyc = 0;
  int rx_idle_pct = 61;
  int tx_idle_pct = 36;
  logic rx_hold_go = 1'b0;
  logic rx_hold_used = 1'b0;
  int rx_hold_left = 0;
  int live_words = 0;
  int cur_wait = 2;
  logic [31:0] clock_ms = '0;

  int strict_set [PHASES] = '{0, 2, 3, 1, 1, 2};
  int retry_set  [PHASES] = '{15, 3, 0, 2, 15, 1};
  int wait_set   [PHASES] = '{0, 63, 1, 5, 0, 3};
  int src_set    [PHASES] = '{2, 0, 3, 1, 2, 1};

  landing_retry_supervisor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  landing_decision_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .pending(pending), .mismatches(mismatches)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_go && !rx_hold_used) begin
      rx_hold_used <= 1'b1;
      rx_hold_left <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic logic signed [23:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'($urandom_range(0, 400) - 200);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic in_item_t fresh_word(input logic [2:0] act);
    in_item_t w;
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(1, 2500);
    w.action              = act;
    w.now_ms              = clock_ms;
    w.target_age_ms       = $urandom();
    w.pilot_repositioning = ($urandom_range(0, 19) == 0);
    w.err_xy_cm           = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 50))
                                                        : 16'($urandom());
    w.err_z_cm            = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 100) - 50)
                                                        : 16'($urandom());
    w.target_x_cm         = pick_pos();
    w.target_y_cm         = pick_pos();
    w.target_z_cm         = pick_pos();
    w.vehicle_x_cm        = pick_pos();
    w.vehicle_y_cm        = pick_pos();
    w.vehicle_z_cm        = pick_pos();
    return w;
  endfunction

  function automatic in_item_t quiet_word(input logic [2:0] act);
    in_item_t w;
    w = fresh_word(act);
    w.pilot_repositioning = 1'b0;
    w.err_xy_cm = 16'd1000;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    in_tvalid <= 1'b1;
    in_tuser  <= w.action;
    in_tdata  <= {7'd0, w.vehicle_z_cm, w.vehicle_y_cm, w.vehicle_x_cm, w.target_z_cm,
                  w.target_y_cm, w.target_x_cm, w.err_z_cm, w.err_xy_cm,
                  w.pilot_repositioning, w.target_age_ms, w.now_ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // idle cycles after a word: each cycle idles with probability tx_idle_pct
  task automatic offer(input in_item_t w);
    send_word(w);
    if (w.action <= ACT_NEVER_SEEN) live_words++;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_words();
    in_item_t w;
    int k;
    w = '0;
    w.action = ACT_RESTART;
    offer(w);
    w = '1;
    w.action = ACT_FOUND;
    offer(w);
    offer(quiet_word(ACT_OUT_OF_RNG));
    offer(quiet_word(ACT_RECENT_LOST));
    w = quiet_word(ACT_RECENT_LOST);
    w.target_age_ms = 32'd0;
    offer(w);
    w.target_age_ms = 32'd1999;
    offer(w);
    w.target_age_ms = 32'd2000;
    offer(w);
    // retry start from the vehicle point at the coordinate limits
    w.vehicle_x_cm = 24'sh800000;
    w.vehicle_y_cm = 24'sh7FFFFF;
    w.vehicle_z_cm = 24'sh800000;
    offer(w);
    w.err_xy_cm = 16'd35;
    w.err_z_cm = 16'sd0;
    offer(w);
    w.err_xy_cm = 16'd34;
    w.err_z_cm = -16'sd34;
    offer(w);
    w.err_xy_cm = 16'd1000;
    w.now_ms = 32'd1000;
    offer(w);
    w.now_ms = 32'd7999;
    offer(w);
    w.now_ms = 32'd8000;
    offer(w);
    w.action = ACT_NEVER_SEEN;
    w.now_ms = 32'd9000;
    offer(w);
    for (k = 5; k < 8; k++) offer(fresh_word(3'(k)));
    offer(quiet_word(ACT_FOUND));
    offer(quiet_word(ACT_RECENT_LOST));
    w = quiet_word(ACT_RECENT_LOST);
    w.target_age_ms = '1;
    offer(w);
    w.vehicle_z_cm = 24'sh7FFFFF;
    offer(w);
    w.err_xy_cm = 16'd0;
    w.err_z_cm = 16'sh8000;
    offer(w);
    // pilot takes over, failsafe timer straddles the time wrap
    w.pilot_repositioning = 1'b1;
    w.now_ms = 32'hFFFFF000;
    offer(w);
    w.action = ACT_NEVER_SEEN;
    w.now_ms = 32'h00000800;
    offer(w);
    w = quiet_word(ACT_RESTART);
    offer(w);
  endtask

  task automatic run_episode();
    in_item_t w;
    logic [31:0] age;
    int n, k;
    if ($urandom_range(0, 6) == 0) offer(fresh_word(ACT_RESTART));
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++)
      offer(fresh_word($urandom_range(0, 1) ? ACT_FOUND : ACT_OUT_OF_RNG));
    age = '0;
    n = $urandom_range(2, 30);
    for (k = 0; k < n; k++) begin
      w = fresh_word(ACT_RECENT_LOST);
      if ($urandom_range(0, 9) != 0) w.target_age_ms = age;
      age = age + $urandom_range(0, cur_wait * 400 + 600);
      if ($urandom_range(0, 1) == 1) begin
        w.err_xy_cm = 16'($urandom_range(0, 40));
        w.err_z_cm = 16'($urandom_range(0, 80) - 40);
      end
      offer(w);
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) offer(fresh_word(ACT_NEVER_SEEN));
    end
    if ($urandom_range(0, 4) == 0) offer(fresh_word(3'($urandom_range(0, 7))));
  endtask

  initial begin
    int p, goal;
    logic paused;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    for (p = 0; p < PHASES; p++) begin
      drain();
      apb_write(REG_STRICTNESS, 32'(strict_set[p]));
      apb_write(REG_MAX_RETRIES, 32'(retry_set[p]));
      apb_write(REG_MIN_WAIT_S, 32'(wait_set[p]));
      apb_write(REG_RETRY_SRC, 32'(src_set[p]));
      cur_wait = wait_set[p];
      case (p / 2)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct <= 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct <= 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (p == 1) rx_hold_go <= 1'b1;
      goal = live_words + PHASE_WORDS;
      paused = 1'b0;
      while (live_words < goal) begin
        run_episode();
        if (!paused && live_words > goal - 80) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();
    if (mismatches == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
